FILE: rtl/core/bbrt_pkg.sv
// ----------------------------------------------------------------------------
// bbrt_pkg: shared types and constants for the bright blob run tracker
// Payload structs, register indexes, field widths and reset values.
// ----------------------------------------------------------------------------
package bbrt_pkg;

	localparam int LUMA_W  = 8;
	localparam int COUNT_W = 21;
	localparam int XSUM_W  = 31;
	localparam int YSUM_W  = 30;
	localparam int DEV_W   = 4;

	localparam int CFG_ADDR_W = 2;
	localparam int CFG_DATA_W = 8;

	localparam int DEF_SLOTS     = 4;
	localparam int DEF_MAX_WIDTH = 1024;
	localparam int DEF_MAX_ROWS  = 1024;

	localparam logic [LUMA_W-1:0] BRIGHT_RESET = 8'd200;
	localparam logic [LUMA_W-1:0] DARK_RESET   = 8'd150;
	localparam logic [DEV_W-1:0]  SOURCE_RESET = 4'd0;

	typedef enum logic [CFG_ADDR_W-1:0] {
		REG_BRIGHT = 2'd0,
		REG_DARK   = 2'd1,
		REG_SOURCE = 2'd2
	} bbrt_reg_t;

	typedef struct packed {
		logic [LUMA_W-1:0] luma;
		logic              frame_start;
		logic              row_end;
	} bbrt_pix_t;

	typedef struct packed {
		logic [COUNT_W-1:0] pixel_count;
		logic [XSUM_W-1:0]  double_sum_x;
		logic [YSUM_W-1:0]  weighted_sum_y;
		logic [DEV_W-1:0]   device_number;
		logic               last_of_run;
	} bbrt_blob_t;

	// accumulated moments of one blob
	typedef struct packed {
		logic [COUNT_W-1:0] count;
		logic [XSUM_W-1:0]  xsum;
		logic [YSUM_W-1:0]  ysum;
	} bbrt_rec_t;

	// per-pixel commands to the slot array, already qualified by the pixel step
	typedef struct packed {
		logic step;
		logic clear;
		logic merge;
		logic flush;
	} bbrt_cmd_t;

endpackage

FILE: rtl/core/bbrt_slots.sv
// ----------------------------------------------------------------------------
// bbrt_slots: blob slot array
// Merges closed runs into overlapping slots or a free one, and flags the
// slots that finish at a row end.
// ----------------------------------------------------------------------------
module bbrt_slots import bbrt_pkg::*; #(
	parameter int SLOTS = DEF_SLOTS,
	parameter int CW    = 10,
	parameter int RW    = 10
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  bbrt_cmd_t               cmd,
	input  logic [CW-1:0]           run_left,
	input  logic [CW-1:0]           run_right,
	input  logic [RW-1:0]           row,
	output logic [SLOTS-1:0]        emit,
	output bbrt_rec_t [SLOTS-1:0]   recs
);

	logic [SLOTS-1:0] used_q;
	logic [SLOTS-1:0] used_eff;
	logic [SLOTS-1:0] hit;
	logic [SLOTS-1:0] fresh;
	logic [CW-1:0]    left_q     [SLOTS];
	logic [CW-1:0]    right_q    [SLOTS];
	logic [RW-1:0]    last_row_q [SLOTS];
	bbrt_rec_t        rec_q      [SLOTS];

	logic             run_ok;
	logic [CW-1:0]    len;
	logic [CW:0]      span_sum;
	logic [2*CW:0]    xs_full;
	logic [CW+RW-1:0] ys_full;
	logic [COUNT_W-1:0] len_c;
	logic [XSUM_W-1:0]  xs_c;
	logic [YSUM_W-1:0]  ys_c;

	// span moments: len, len*(left+right), len*row
	assign run_ok   = cmd.merge && (run_right > run_left);
	assign len      = run_right - run_left;
	assign span_sum = {1'b0, run_right} + {1'b0, run_left};
	assign xs_full  = (2*CW+1)'(len) * (2*CW+1)'(span_sum);
	assign ys_full  = (CW+RW)'(len) * (CW+RW)'(row);
	assign len_c    = COUNT_W'(len);
	assign xs_c     = XSUM_W'(xs_full);
	assign ys_c     = YSUM_W'(ys_full);

	assign used_eff = cmd.clear ? '0 : used_q;

	always_comb begin
		logic any_hit;
		logic taken;
		any_hit = 1'b0;
		taken   = 1'b0;
		for (int i = 0; i < SLOTS; i++) begin
			hit[i] = run_ok && used_eff[i] && (run_left < right_q[i]) &&
				(left_q[i] < run_right);
			any_hit = any_hit | hit[i];
		end
		// no overlap: highest-numbered free slot opens a new blob
		for (int i = SLOTS - 1; i >= 0; i--) begin
			fresh[i] = run_ok && !any_hit && !used_eff[i] && !taken;
			taken    = taken | !used_eff[i];
		end
		for (int i = 0; i < SLOTS; i++) begin
			emit[i] = cmd.flush && used_eff[i] && !hit[i] && !fresh[i] &&
				(last_row_q[i] != row);
			recs[i] = rec_q[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= '0;
		end else if (cmd.step) begin
			used_q <= (used_eff | fresh) & ~emit;
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < SLOTS; i++) begin
			if (hit[i] || fresh[i]) begin
				rec_q[i].count <= hit[i] ? rec_q[i].count + len_c : len_c;
				rec_q[i].xsum  <= hit[i] ? rec_q[i].xsum + xs_c : xs_c;
				rec_q[i].ysum  <= hit[i] ? rec_q[i].ysum + ys_c : ys_c;
				left_q[i]      <= run_left;
				right_q[i]     <= run_right;
				last_row_q[i]  <= row;
			end
		end
	end

endmodule

FILE: rtl/core/bright_blob_run_tracker_unit.sv
// ----------------------------------------------------------------------------
// bright_blob_run_tracker_unit: run-length bright blob detector
// Tracks bright runs over a luma raster and reports finished blobs with
// pixel count and x/y moments at each row end.
// ----------------------------------------------------------------------------
// Flow: a pixel request is held in the input register and processed from
// there; its blob results are registered into the result buffer.
// Throughput: one pixel per cycle. Results leave at one per cycle, while
// blob_ready is high, from an SLOTS-deep result buffer; a row-end pixel
// holds in the input register until the previous row's results have all
// been taken.
// Reset: clears counters, open run, slot valid bits and pending results;
// thresholds return to 200/150 and source id to 0.
// ----------------------------------------------------------------------------
module bright_blob_run_tracker_unit import bbrt_pkg::*; #(
	parameter int SLOTS     = DEF_SLOTS,
	parameter int MAX_WIDTH = DEF_MAX_WIDTH,
	parameter int MAX_ROWS  = DEF_MAX_ROWS
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// pixel channel
	input  logic                  pix_valid,
	output logic                  pix_ready,
	input  bbrt_pix_t             pix,
	// blob result channel
	output logic                  blob_valid,
	input  logic                  blob_ready,
	output bbrt_blob_t            blob,
	// register writes
	input  logic                  cfg_we,
	input  logic [CFG_ADDR_W-1:0] cfg_addr,
	input  logic [CFG_DATA_W-1:0] cfg_wdata
);

	localparam int CW = $clog2(MAX_WIDTH);
	localparam int RW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
	localparam logic [CW-1:0] COL_LAST = CW'(MAX_WIDTH - 1);
	localparam logic [RW-1:0] ROW_LAST = RW'(MAX_ROWS - 1);

	// configuration registers
	logic [LUMA_W-1:0] bright_q;
	logic [LUMA_W-1:0] dark_q;
	logic [DEV_W-1:0]  src_q;

	// input register
	logic      pix_valid_s1;
	bbrt_pix_t pix_s1;

	// raster and run state
	logic          in_run_q;
	logic [CW-1:0] run_left_q;
	logic [CW-1:0] column_q;
	logic [RW-1:0] row_q;

	// result buffer: one entry per slot, drained lowest index first
	logic [SLOTS-1:0] pend_q;
	bbrt_rec_t        buf_q [SLOTS];

	logic                 consume;
	logic                 fs;
	logic                 run_eff;
	logic [CW-1:0]        col_eff;
	logic [RW-1:0]        row_eff;
	logic                 is_dark;
	logic                 is_bright;
	bbrt_cmd_t            cmd;
	logic [SLOTS-1:0]     emit;
	bbrt_rec_t [SLOTS-1:0] recs;
	logic                 pop;
	logic [SLOTS-1:0]     low;
	bbrt_rec_t            sel_rec;

	// ---------------- configuration ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bright_q <= BRIGHT_RESET;
			dark_q   <= DARK_RESET;
			src_q    <= SOURCE_RESET;
		end else if (cfg_we) begin
			case (cfg_addr)
				REG_BRIGHT: bright_q <= cfg_wdata;
				REG_DARK:   dark_q   <= cfg_wdata;
				REG_SOURCE: src_q    <= cfg_wdata[DEV_W-1:0];
				default: ;
			endcase
		end
	end

	// ---------------- input register ----------------
	// A row-end pixel needs the result buffer empty; every other pixel
	// moves on at once.
	assign consume   = pix_valid_s1 && (!pix_s1.row_end || (pend_q == '0));
	assign pix_ready = !pix_valid_s1 || consume;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pix_valid_s1 <= 1'b0;
		end else if (pix_ready) begin
			pix_valid_s1 <= pix_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (pix_valid && pix_ready) begin
			pix_s1 <= pix;
		end
	end

	// ---------------- pixel classification ----------------
	// frame start wipes the raster state before this pixel is looked at
	assign fs      = pix_s1.frame_start;
	assign run_eff = fs ? 1'b0 : in_run_q;
	assign col_eff = fs ? '0 : column_q;
	assign row_eff = fs ? '0 : row_q;

	// dark wins when the thresholds are crossed
	assign is_dark   = pix_s1.luma < dark_q;
	assign is_bright = !is_dark && (pix_s1.luma >= bright_q);

	assign cmd.step  = consume;
	assign cmd.clear = consume && fs;
	assign cmd.merge = consume && is_dark && run_eff;
	assign cmd.flush = consume && pix_s1.row_end;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_run_q   <= 1'b0;
			run_left_q <= '0;
			column_q   <= '0;
			row_q      <= '0;
		end else if (consume) begin
			// open run is dropped at row end
			if (pix_s1.row_end || is_dark) begin
				in_run_q <= 1'b0;
			end else if (is_bright) begin
				in_run_q <= 1'b1;
			end else begin
				in_run_q <= run_eff;
			end
			if (is_bright && !run_eff) begin
				run_left_q <= col_eff;
			end else if (fs) begin
				run_left_q <= '0;
			end
			// column and row saturate at the raster limits
			if (pix_s1.row_end) begin
				column_q <= '0;
				row_q    <= (row_eff != ROW_LAST) ? row_eff + 1'b1 : row_eff;
			end else begin
				column_q <= (col_eff != COL_LAST) ? col_eff + 1'b1 : col_eff;
				row_q    <= row_eff;
			end
		end
	end

	// ---------------- slot array ----------------
	// closing pixel's column is the exclusive right end of the run
	bbrt_slots #(
		.SLOTS (SLOTS),
		.CW    (CW),
		.RW    (RW)
	) u_slots (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.run_left  (run_left_q),
		.run_right (col_eff),
		.row       (row_eff),
		.emit      (emit),
		.recs      (recs)
	);

	// ---------------- result buffer ----------------
	// Finished slots are copied out at the row end, so the slot array is
	// free to reuse them while results drain.
	assign pop = blob_valid && blob_ready;
	assign low = pend_q & (~pend_q + SLOTS'(1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else if (cmd.flush) begin
			pend_q <= emit;
		end else if (pop) begin
			pend_q <= pend_q & ~low;
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < SLOTS; i++) begin
			if (cmd.flush && emit[i]) begin
				buf_q[i] <= recs[i];
			end
		end
	end

	always_comb begin
		sel_rec = '0;
		for (int i = 0; i < SLOTS; i++) begin
			if (low[i]) begin
				sel_rec = sel_rec | buf_q[i];
			end
		end
	end

	assign blob_valid          = |pend_q;
	assign blob.pixel_count    = sel_rec.count;
	assign blob.double_sum_x   = sel_rec.xsum;
	assign blob.weighted_sum_y = sel_rec.ysum;
	assign blob.device_number  = src_q;
	assign blob.last_of_run    = (pend_q & ~low) == '0;

`ifndef ASSERT_OFF
	// the last flag marks the only result still pending
	a_last_single: assert property (@(posedge clk) disable iff (!arst_n)
		blob_valid && blob.last_of_run |-> $onehot(pend_q))
		else $error("last_of_run with more results pending");

	// a taken result that is not the last is followed by another
	a_run_continues: assert property (@(posedge clk) disable iff (!arst_n)
		pop && !blob.last_of_run |=> blob_valid)
		else $error("result run ended without last flag");

	// the last result empties the buffer
	a_run_ends: assert property (@(posedge clk) disable iff (!arst_n)
		pop && blob.last_of_run |=> !blob_valid)
		else $error("results pending after last flag");

	// a row-end pixel restarts the column count
	a_column_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		consume && pix_s1.row_end |=> column_q == '0)
		else $error("column not cleared at row end");
`endif

endmodule
